FILE: hw/rtl/address_hit_count_profiler_top_assert.svh
// Assertion helpers for the profiler checker.
`ifndef ADDRESS_HIT_COUNT_PROFILER_TOP_ASSERT_SVH
`define ADDRESS_HIT_COUNT_PROFILER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AHCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AHCP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ahcp_pkg.sv
`default_nettype none
package ahcp_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	localparam int CNT_W   = 8;
	localparam int ADDR_W  = 32;
	localparam int RIDX_W  = 16;
	localparam int WSIZE_W = 17;
	localparam int ACT_W   = 2;

	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	localparam logic [ACT_W-1:0] ACT_EXEC  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_ENABLE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_START_OFFSET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STOP_ENABLE  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STOP_OFFSET  = 3'd5;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 17'd65536;

endpackage
`default_nettype wire

FILE: hw/rtl/ahcp_ram.sv
`default_nettype none
module ahcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/address_hit_count_profiler_top.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      action, exec_address, read_index
// result    out        result_valid / result_ready  hit_count, counted, in_window, logging_now
// config    in         APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// An item that needs a counter (executed address in the window, or an in-range read)
// goes through ST_READ: the synchronous counter RAM read is registered, then ST_READ updates,
// writes back and loads the result register. Every other item loads it straight from ST_IDLE.
// Reset and the begin action both sweep all STORE_DEPTH (65536) entries of the counter RAM,
// one entry per cycle; item_ready stays low meanwhile, config writes still land.
// A new item is taken only when the result register is empty or drains in that cycle.
`default_nettype none
module address_hit_count_profiler_top
	import ahcp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [ACT_W-1:0]   action,
	input  wire logic [ADDR_W-1:0]  exec_address,
	input  wire logic [RIDX_W-1:0]  read_index,

	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic      [CNT_W-1:0]   hit_count,
	output logic                    counted,
	output logic                    in_window,
	output logic                    logging_now,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(STORE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] DEPTH_EXT = ADDR_W'(STORE_DEPTH);

	// configuration registers
	logic [ADDR_W-1:0]  window_base_q;
	logic [WSIZE_W-1:0] window_size_q;
	logic               start_enable_q;
	logic [ADDR_W-1:0]  start_offset_q;
	logic               stop_enable_q;
	logic [ADDR_W-1:0]  stop_offset_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	// control state
	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
	logic             logging_q, logging_d;
	logic             exec_q, exec_d;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic             result_valid_q;

	// result payload
	logic [CNT_W-1:0] hit_count_q;
	logic             counted_q;
	logic             in_window_q;
	logic             logging_now_q;

	logic             res_load;
	logic [CNT_W-1:0] res_hit;
	logic             res_cnt;
	logic             res_win;
	logic             res_log;

	// RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [CNT_W-1:0] ram_rdata;

	// item decode
	logic              accept;
	logic [ADDR_W-1:0] offset;
	logic [ADDR_W-1:0] eff_size;
	logic              win_hit;
	logic              start_hit;
	logic              stop_hit;
	logic              flag_exec;
	logic [ADDR_W-1:0] ridx_ext;
	logic              ridx_ok;
	logic              incr;
	logic [CNT_W-1:0]  cnt_inc;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q  <= '0;
			window_size_q  <= WSIZE_RESET;
			start_enable_q <= 1'b0;
			start_offset_q <= '0;
			stop_enable_q  <= 1'b0;
			stop_offset_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WINDOW_BASE:  window_base_q  <= pwdata;
				REG_WINDOW_SIZE:  window_size_q  <= pwdata[WSIZE_W-1:0];
				REG_START_ENABLE: start_enable_q <= pwdata[0];
				REG_START_OFFSET: start_offset_q <= pwdata;
				REG_STOP_ENABLE:  stop_enable_q  <= pwdata[0];
				REG_STOP_OFFSET:  stop_offset_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_BASE:  prdata = window_base_q;
			REG_WINDOW_SIZE:  prdata = DATA_W'(window_size_q);
			REG_START_ENABLE: prdata = DATA_W'(start_enable_q);
			REG_START_OFFSET: prdata = start_offset_q;
			REG_STOP_ENABLE:  prdata = DATA_W'(stop_enable_q);
			REG_STOP_OFFSET:  prdata = stop_offset_q;
			default:          prdata = '0;
		endcase
	end

	// ---------------- item decode ----------------
	assign item_ready = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
	assign accept     = item_valid && item_ready;

	// Trigger address equals base + trigger offset exactly when offset matches.
	assign offset    = exec_address - window_base_q;
	assign eff_size  = (ADDR_W'(window_size_q) > DEPTH_EXT) ? DEPTH_EXT
	                                                        : ADDR_W'(window_size_q);
	assign win_hit   = offset < eff_size;
	assign start_hit = start_enable_q && (offset == start_offset_q);
	assign stop_hit  = stop_enable_q && (offset == stop_offset_q);
	assign flag_exec = stop_hit ? 1'b0 : (start_hit ? 1'b1 : logging_q);

	assign ridx_ext = ADDR_W'(read_index);
	assign ridx_ok  = ridx_ext < DEPTH_EXT;

	assign cnt_inc = ram_rdata + 8'd1;
	assign incr    = exec_q && logging_q && (ram_rdata != CNT_MAX);

	always_comb begin
		state_d   = state_q;
		clr_cnt_d = clr_cnt_q;
		logging_d = logging_q;
		exec_d    = exec_q;
		addr_d    = addr_q;

		res_load = 1'b0;
		res_hit  = '0;
		res_cnt  = 1'b0;
		res_win  = 1'b0;
		res_log  = logging_q;

		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = (action == ACT_EXEC) ? offset[IDX_W-1:0] : ridx_ext[IDX_W-1:0];

		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_cnt_q == IDX_LAST) begin
					clr_cnt_d = '0;
					state_d   = ST_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					addr_d = ram_raddr;
					unique case (action)
						ACT_EXEC: begin
							logging_d = flag_exec;
							exec_d    = 1'b1;
							if (win_hit) begin
								ram_re  = 1'b1;
								state_d = ST_READ;
							end else begin
								res_load = 1'b1;
								res_log  = flag_exec;
							end
						end
						ACT_READ: begin
							exec_d = 1'b0;
							if (ridx_ok) begin
								ram_re  = 1'b1;
								state_d = ST_READ;
							end else begin
								res_load = 1'b1;
							end
						end
						ACT_BEGIN: begin
							logging_d = !start_enable_q;
							res_load  = 1'b1;
							res_log   = !start_enable_q;
							state_d   = ST_CLEAR;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				// update the counter just read and write it back
				res_load  = 1'b1;
				res_hit   = incr ? cnt_inc : ram_rdata;
				res_cnt   = incr;
				res_win   = exec_q;
				ram_we    = incr;
				ram_waddr = addr_q;
				ram_wdata = cnt_inc;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			logging_q      <= 1'b1;
			exec_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
			logging_q <= logging_d;
			exec_q    <= exec_d;
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (res_load) begin
			hit_count_q   <= res_hit;
			counted_q     <= res_cnt;
			in_window_q   <= res_win;
			logging_now_q <= res_log;
		end
	end

	assign result_valid = result_valid_q;
	assign hit_count    = hit_count_q;
	assign counted      = counted_q;
	assign in_window    = in_window_q;
	assign logging_now  = logging_now_q;

	ahcp_ram #(
		.WIDTH(CNT_W),
		.DEPTH(STORE_DEPTH)
	) u_counters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/ahcp_checker.sv
`default_nettype none
`include "address_hit_count_profiler_top_assert.svh"
module ahcp_checker
	import ahcp_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_ready,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic [CNT_W-1:0]   hit_count,
	input wire logic               counted,
	input wire logic               in_window,
	input wire logic               logging_now
);

	`AHCP_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(hit_count) && $stable(counted) && $stable(in_window) && $stable(logging_now), "stalled result beat changed")
	`AHCP_ASSERT_NOW(a_counted_in_window, result_valid && counted, in_window && (hit_count != 8'd0), "count outside the window or zero after increment")
	`AHCP_ASSERT_NOW(a_counted_logging, result_valid && counted, logging_now, "counted while logging is off")
	`AHCP_ASSERT_NXT(a_ready_after_reset, $rose(arst_n), !item_ready, "item taken before counter sweep")

endmodule

bind address_hit_count_profiler_top ahcp_checker u_ahcp_checker (.*);
`default_nettype wire

FILE: dv/tb_address_hit_count_profiler_top.sv
`default_nettype none
module tb_address_hit_count_profiler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ahcp_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned RUN_LIMIT = 3_000_000;

	typedef struct packed {
		logic [CNT_W-1:0] hit_count;
		logic             counted;
		logic             in_window;
		logic             logging_now;
	} hit_outcome_t;

	class hit_count_scoreboard;
		logic [ADDR_W-1:0]  window_base;
		logic [WSIZE_W-1:0] window_size;
		logic               start_enable;
		logic [ADDR_W-1:0]  start_offset;
		logic               stop_enable;
		logic [ADDR_W-1:0]  stop_offset;
		logic               logging;
		logic [CNT_W-1:0]   counters [STORE_DEPTH];
		hit_outcome_t       awaited [$];
		int                 fail_count;

		function new();
			window_base = '0;
			window_size = WSIZE_RESET;
			start_enable = 1'b0;
			start_offset = '0;
			stop_enable = 1'b0;
			stop_offset = '0;
			logging = 1'b1;
			foreach (counters[i]) counters[i] = '0;
			fail_count = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
			REG_WINDOW_BASE:  window_base = val;
			REG_WINDOW_SIZE:  window_size = val[WSIZE_W-1:0];
			REG_START_ENABLE: start_enable = val[0];
			REG_START_OFFSET: start_offset = val;
			REG_STOP_ENABLE:  stop_enable = val[0];
			REG_STOP_OFFSET:  stop_offset = val;
			default: ;
			endcase
		endfunction

		function int unsigned span();
			return (window_size > STORE_DEPTH) ? STORE_DEPTH : window_size;
		endfunction

		function void note_item(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
				logic [RIDX_W-1:0] idx);
			hit_outcome_t o;
			logic [ADDR_W-1:0] off;
			o = '0;
			case (act)
			ACT_EXEC: begin
				// start check first, then stop, then count
				if (start_enable && addr == window_base + start_offset)
					logging = 1'b1;
				if (stop_enable && addr == window_base + stop_offset)
					logging = 1'b0;
				off = addr - window_base;
				if (off < span()) begin
					o.in_window = 1'b1;
					if (logging && counters[off[IDX_W-1:0]] != CNT_MAX) begin
						counters[off[IDX_W-1:0]] = counters[off[IDX_W-1:0]] + 1'b1;
						o.counted = 1'b1;
					end
					o.hit_count = counters[off[IDX_W-1:0]];
				end
			end
			ACT_READ: begin
				o.hit_count = counters[idx];
			end
			ACT_BEGIN: begin
				foreach (counters[i]) counters[i] = '0;
				logging = !start_enable;
			end
			default: ;
			endcase
			o.logging_now = logging;
			awaited.push_back(o);
		endfunction

		task report(string msg);
			fail_count++;
			$display("[%0t] %s", $time, msg);
		endtask

		task check_result(hit_outcome_t got);
			hit_outcome_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result beat with nothing pending: hit_count=%0d", got.hit_count));
				return;
			end
			want = awaited.pop_front();
			if (got.hit_count !== want.hit_count)
				report($sformatf("hit_count %0d, want %0d", got.hit_count, want.hit_count));
			if (got.counted !== want.counted)
				report($sformatf("counted %b, want %b", got.counted, want.counted));
			if (got.in_window !== want.in_window)
				report($sformatf("in_window %b, want %b", got.in_window, want.in_window));
			if (got.logging_now !== want.logging_now)
				report($sformatf("logging_now %b, want %b", got.logging_now, want.logging_now));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic [ACT_W-1:0]     action = ACT_EXEC;
	logic [ADDR_W-1:0]    exec_address = '0;
	logic [RIDX_W-1:0]    read_index = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [CNT_W-1:0]     hit_count;
	logic                 counted;
	logic                 in_window;
	logic                 logging_now;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	logic                 calm = 1'b0;
	int unsigned          ready_hold = 0;
	int unsigned          cycle_count = 0;
	hit_count_scoreboard  sb;

	address_hit_count_profiler_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stall bursts, long ready stretches, none when calm
	always @(posedge clk) begin
		if (calm) begin
			result_ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			result_ready <= 1'b0;
			ready_hold <= $urandom_range(1, 13) - 1;
		end else begin
			result_ready <= 1'b1;
			ready_hold <= $urandom_range(1, 24) - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result({hit_count, counted, in_window, logging_now});
	end

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [RIDX_W-1:0] idx);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		exec_address <= addr;
		read_index <= idx;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sb.note_item(act, addr, idx);
	endtask

	// hold off until every pending result beat has come back
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] base, input logic [WSIZE_W-1:0] size,
			input logic sen, input logic [ADDR_W-1:0] soff,
			input logic pen, input logic [ADDR_W-1:0] poff);
		drain();
		// let any clearing sweep finish before touching the registers
		while (!item_ready) @(posedge clk);
		apb_write(REG_WINDOW_BASE, base);
		apb_write(REG_WINDOW_SIZE, DATA_W'(size));
		apb_write(REG_START_ENABLE, DATA_W'(sen));
		apb_write(REG_START_OFFSET, soff);
		apb_write(REG_STOP_ENABLE, DATA_W'(pen));
		apb_write(REG_STOP_OFFSET, poff);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly addresses near the window and the trigger points, some noise
	function automatic void pick_item(output logic [ACT_W-1:0] act,
			output logic [ADDR_W-1:0] addr, output logic [RIDX_W-1:0] idx);
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(0, 99);
		span = sb.span();
		addr = $urandom;
		idx = RIDX_W'($urandom);
		act = ACT_EXEC;
		if (pick < 62) begin
			case ($urandom_range(0, 9))
			0, 1: addr = sb.window_base + sb.start_offset;
			2, 3: addr = sb.window_base + sb.stop_offset;
			4, 5, 6, 7: addr = sb.window_base +
				$urandom_range(0, (span > 16) ? 15 : ((span == 0) ? 0 : span - 1));
			8: addr = sb.window_base + span - $urandom_range(0, 1);
			default: ;
			endcase
		end else if (pick < 90) begin
			act = ACT_READ;
			if ($urandom_range(0, 9) < 7)
				idx = RIDX_W'($urandom_range(0, 15));
		end else if (pick < 96) begin
			act = ACT_UNUSED;
		end
	endfunction

	initial begin
		logic [ACT_W-1:0]  act;
		logic [ADDR_W-1:0] addr;
		logic [RIDX_W-1:0] idx;
		logic [ADDR_W-1:0] target;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// default window from reset: base 0, full store, no triggers
		send_item(ACT_EXEC, 32'h0000_0000, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0000_0000, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0000_FFFF, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0001_0000, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'hFFFF_FFFF, RIDX_W'($urandom));
		send_item(ACT_READ, $urandom, 16'h0000);
		send_item(ACT_READ, $urandom, 16'hFFFF);
		send_item(ACT_UNUSED, 32'h0000_0000, 16'h0000);
		send_item(ACT_READ, $urandom, 16'h0000);
		send_item(ACT_BEGIN, $urandom, RIDX_W'($urandom));
		send_item(ACT_READ, $urandom, 16'h0000);

		// window wrapping past the top of the address space, both triggers
		configure(32'hFFFF_FFF0, 17'd32, 1'b1, 32'd4, 1'b1, 32'd8);
		send_item(ACT_BEGIN, $urandom, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'hFFFF_FFF0, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'hFFFF_FFF4, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0000_000F, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0000_0010, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'hFFFF_FFF8, RIDX_W'($urandom));
		send_item(ACT_READ, $urandom, 16'd31);

		// start and stop on the same address: stop wins
		configure(32'hFFFF_FFFF, 17'd1, 1'b1, 32'd0, 1'b1, 32'd0);
		send_item(ACT_EXEC, 32'hFFFF_FFFF, RIDX_W'($urandom));
		send_item(ACT_EXEC, 32'h0000_0000, RIDX_W'($urandom));

		// empty window, start trigger still fires
		configure(32'hFFFF_FFFF, 17'd0, 1'b1, 32'd0, 1'b0, 32'hFFFF_FFFF);
		send_item(ACT_EXEC, 32'hFFFF_FFFF, RIDX_W'($urandom));
		send_item(ACT_READ, $urandom, 16'd0);

		// hammer one offset toward saturation
		configure($urandom, 17'd16, 1'b0, $urandom, 1'b0, $urandom);
		send_item(ACT_BEGIN, $urandom, RIDX_W'($urandom));
		target = sb.window_base + 32'd3;
		for (int n = 0; n < 280; n++) begin
			if (n == 140)
				drain();
			case ($urandom_range(0, 19))
			0: pick_item(act, addr, idx);
			1: begin
				act = ACT_READ;
				addr = $urandom;
				idx = 16'd3;
			end
			default: begin
				act = ACT_EXEC;
				addr = target;
				idx = RIDX_W'($urandom);
			end
			endcase
			send_item(act, addr, idx);
		end

		// full-size window, triggers inside it, armed by begin
		configure($urandom, WSIZE_RESET, 1'b1, $urandom_range(0, 15), 1'b1,
			$urandom_range(0, 15));
		send_item(ACT_BEGIN, $urandom, RIDX_W'($urandom));
		for (int n = 0; n < 150; n++) begin
			pick_item(act, addr, idx);
			send_item(act, addr, idx);
		end

		// closing stretch at full rate on both sides
		configure($urandom, WSIZE_W'($urandom_range(1, 64)), 1'b0, $urandom, 1'b1,
			$urandom_range(0, 63));
		calm = 1'b1;
		for (int n = 0; n < 100; n++) begin
			pick_item(act, addr, idx);
			send_item(act, addr, idx);
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report($sformatf("%0d result beats never arrived", sb.awaited.size()));
		if (sb.fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/ahcp_pkg.sv
hw/rtl/ahcp_ram.sv
hw/rtl/address_hit_count_profiler_top.sv
hw/rtl/ahcp_checker.sv
dv/tb_address_hit_count_profiler_top.sv
